[rtl/point_rotate_translate_project_assert.svh]
// Assertion macros for the point rotate / translate / project block.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef POINT_ROTATE_TRANSLATE_PROJECT_ASSERT_SVH
`define POINT_ROTATE_TRANSLATE_PROJECT_ASSERT_SVH

// same-cycle implication
`define PRTP_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PRTP_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/prtp_pkg.sv]
// Shared types and constants of the point rotate / translate / project block.
// No dependencies.
package prtp_pkg;

    localparam logic [1:0] FN_ROTATE    = 2'd0;
    localparam logic [1:0] FN_TRANSLATE = 2'd1;
    localparam logic [1:0] FN_PROJECT   = 2'd2;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic [1:0] CFG_FOV = 2'd0;
    localparam logic [1:0] CFG_VX  = 2'd1;
    localparam logic [1:0] CFG_VY  = 2'd2;

    localparam logic [30:0] FOV_RESET = 31'd16777216;

    localparam logic signed [31:0] INT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] INT_MIN = 32'sh80000000;

    localparam int CS_FRAC    = 28;
    localparam int ATAN_COUNT = 24;
    localparam int DIV_QBITS  = 31;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008218;

    typedef logic signed [32:0] t_ang;

    localparam t_ang ATAN_DEG [ATAN_COUNT] = '{
        33'sd754974720, 33'sd445687602, 33'sd235489089, 33'sd119537938,
        33'sd60000934,  33'sd30029717,  33'sd15018523,  33'sd7509720,
        33'sd3754917,   33'sd1877466,   33'sd938734,    33'sd469367,
        33'sd234684,    33'sd117342,    33'sd58671,     33'sd29335,
        33'sd14668,     33'sd7334,      33'sd3667,      33'sd1833,
        33'sd917,       33'sd458,       33'sd229,       33'sd115
    };

    typedef struct packed {
        logic [1:0]         func;
        logic [1:0]         axis;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] amount;
        logic signed [31:0] pivx;
        logic signed [31:0] pivy;
        logic signed [31:0] pivz;
        logic               neg;
    } t_item;

    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic               proj;
        logic               dz;
        logic               negx;
        logic               negz;
        logic               ovfx;
        logic               ovfz;
    } t_res;

endpackage

[rtl/prtp_mod_cell.sv]
// One conditional-subtract step of the angle range reduction.
// Depends on nothing; chained by the top level.
module prtp_mod_cell #(
    parameter int              UW  = 33,
    parameter longint unsigned SUB = 64'd1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [UW-1:0] i_u,
    output logic [UW-1:0] o_u
);

    logic [UW-1:0] r_u;
    logic [UW-1:0] n_u;

    always_comb begin
        n_u = (i_u >= UW'(SUB)) ? i_u - UW'(SUB) : i_u;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u <= n_u;
        end
    end

    assign o_u = r_u;

endmodule

[rtl/prtp_cordic_cell.sv]
// One rotation-mode CORDIC step in degrees, x/y in Q3.28, angle in Q.24.
// Depends on prtp_pkg for the arctangent table.
module prtp_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic signed [32:0] i_z,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y,
    output logic signed [32:0] o_z
);

    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [32:0] r_z;
    logic signed [31:0] n_x;
    logic signed [31:0] n_y;
    logic signed [32:0] n_z;
    logic signed [31:0] xs;
    logic signed [31:0] ys;

    always_comb begin
        xs = i_x >>> IDX;
        ys = i_y >>> IDX;
        if (!i_z[32]) begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - prtp_pkg::ATAN_DEG[IDX];
        end else begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + prtp_pkg::ATAN_DEG[IDX];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

[rtl/prtp_div_cell.sv]
// One restoring-division step producing quotient bit K of an unsigned divide.
// Depends on prtp_pkg for the quotient width.
module prtp_div_cell #(
    parameter int K = 0
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [63:0]                        i_rem,
    input  logic [32:0]                        i_den,
    input  logic [prtp_pkg::DIV_QBITS-1:0]     i_q,
    output logic [63:0]                        o_rem,
    output logic [32:0]                        o_den,
    output logic [prtp_pkg::DIV_QBITS-1:0]     o_q
);

    logic [63:0]                    r_rem;
    logic [32:0]                    r_den;
    logic [prtp_pkg::DIV_QBITS-1:0] r_q;
    logic [63:0]                    n_rem;
    logic [prtp_pkg::DIV_QBITS-1:0] n_q;
    logic [63:0]                    sub;

    always_comb begin
        sub   = 64'(i_den) << K;
        n_rem = i_rem;
        n_q   = i_q;
        if (i_rem >= sub) begin
            n_rem  = i_rem - sub;
            n_q[K] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_q   <= n_q;
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_q   = r_q;

endmodule

[rtl/point_rotate_translate_project.sv]
// Items pass the QW angle-reduction cells (QW = 8 at defaults), the CORDIC cells and the
// 31-cell divider chains on the way from accept to o_valid.
// Throughput: one item per cycle while i_stall is low; every stage is an elastic register with its own valid.
// Reset (synchronous, active low) empties the pipeline and restores the config registers.
// Depends on prtp_pkg, prtp_mod_cell, prtp_cordic_cell, prtp_div_cell and the assert header.
`include "point_rotate_translate_project_assert.svh"
module point_rotate_translate_project #(
    parameter int FRAC_BITS   = 16,
    parameter int TRIG_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_func,
    input  logic [1:0]         i_axis_sel,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic signed [31:0] i_amount,
    input  logic signed [31:0] i_pivot_x,
    input  logic signed [31:0] i_pivot_y,
    input  logic signed [31:0] i_pivot_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic signed [31:0] o_screen_x,
    output logic signed [31:0] o_screen_y,
    output logic               o_divide_error,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam longint unsigned FULL    = 64'd360 << FRAC_BITS;
    localparam longint unsigned HALF    = 64'd180 << FRAC_BITS;
    localparam longint unsigned QUARTER = 64'd90 << FRAC_BITS;
    localparam longint unsigned NMUL    = ((64'd1 << 31) + FULL - 64'd1) / FULL;
    localparam longint unsigned OFF     = FULL * NMUL;
    localparam longint unsigned UMAX    = (64'd1 << 31) + OFF;
    localparam int UW = $clog2(UMAX);
    localparam int QW = $clog2(UMAX / FULL + 64'd1);
    localparam int QB = prtp_pkg::DIV_QBITS;

    localparam int S_FOLD = QW;
    localparam int S_COR0 = QW + 1;
    localparam int S_MUL  = QW + TRIG_STAGES + 1;
    localparam int S_SUM  = S_MUL + 1;
    localparam int S_POST = S_SUM + 1;
    localparam int S_FIN  = S_POST + QB + 1;
    localparam int NS     = S_FIN + 1;

    localparam logic signed [UW:0] FULL_S    = (UW+1)'(FULL);
    localparam logic signed [UW:0] HALF_S    = (UW+1)'(HALF);
    localparam logic signed [UW:0] QUARTER_S = (UW+1)'(QUARTER);

    function automatic logic signed [31:0] sat39(input logic signed [38:0] v);
        logic signed [31:0] r;
        if (v > 39'(prtp_pkg::INT_MAX)) begin
            r = prtp_pkg::INT_MAX;
        end else if (v < 39'(prtp_pkg::INT_MIN)) begin
            r = prtp_pkg::INT_MIN;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    // configuration
    logic [30:0]        r_fov;
    logic signed [31:0] r_vx;
    logic signed [31:0] r_vy;
    logic               cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fov <= prtp_pkg::FOV_RESET;
            r_vx  <= '0;
            r_vy  <= '0;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                prtp_pkg::CFG_FOV: r_fov <= i_cfg_data[30:0];
                prtp_pkg::CFG_VX:  r_vx  <= $signed(i_cfg_data);
                prtp_pkg::CFG_VY:  r_vy  <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // elastic valid chain
    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    assign en[NS-1] = !r_vld[NS-1] || !i_stall;
    for (genvar k = 0; k < NS - 1; k++) begin : g_en
        assign en[k] = !r_vld[k] || en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[NS-1];

    // item shift line
    prtp_pkg::t_item r_item [S_POST];
    prtp_pkg::t_item in_item;
    logic            fold_neg;

    always_comb begin
        in_item.func   = i_func;
        in_item.axis   = i_axis_sel;
        in_item.px     = i_point_x;
        in_item.py     = i_point_y;
        in_item.pz     = i_point_z;
        in_item.amount = i_amount;
        in_item.pivx   = i_pivot_x;
        in_item.pivy   = i_pivot_y;
        in_item.pivz   = i_pivot_z;
        in_item.neg    = 1'b0;
    end

    for (genvar k = 0; k < S_POST; k++) begin : g_item
        prtp_pkg::t_item n_item;
        always_comb begin
            if (k == 0) begin
                n_item = in_item;
            end else begin
                n_item = r_item[(k == 0) ? 0 : k-1];
                if (k == S_FOLD) begin
                    n_item.neg = fold_neg;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_item[k] <= n_item;
            end
        end
    end

    // angle reduction
    logic [UW-1:0] u_ch [QW+1];

    assign u_ch[0] = {{(UW-32){i_amount[31]}}, i_amount} + UW'(OFF);

    for (genvar k = 0; k < QW; k++) begin : g_mod
        prtp_mod_cell #(
            .UW  (UW),
            .SUB (FULL << (QW - 1 - k))
        ) u_mod (
            .i_clk (i_clk),
            .i_en  (en[k]),
            .i_u   (u_ch[k]),
            .o_u   (u_ch[k+1])
        );
    end

    // fold into [-90, 90]
    logic signed [UW:0] fa;
    logic signed [UW:0] fb;
    logic signed [32:0] r_fold_z;

    always_comb begin
        fa = $signed({1'b0, u_ch[QW]});
        if (fa > HALF_S) begin
            fa = fa - FULL_S;
        end
        fb       = fa;
        fold_neg = 1'b0;
        if (fa > QUARTER_S) begin
            fb       = fa - HALF_S;
            fold_neg = 1'b1;
        end else if (fa < -QUARTER_S) begin
            fb       = fa + HALF_S;
            fold_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_FOLD]) begin
            r_fold_z <= 33'(fb) <<< (24 - FRAC_BITS);
        end
    end

    // CORDIC chain
    logic signed [31:0] x_ch [TRIG_STAGES+1];
    logic signed [31:0] y_ch [TRIG_STAGES+1];
    logic signed [32:0] z_ch [TRIG_STAGES+1];

    assign x_ch[0] = prtp_pkg::CORDIC_GAIN;
    assign y_ch[0] = '0;
    assign z_ch[0] = r_fold_z;

    for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cor
        prtp_cordic_cell #(
            .IDX (i)
        ) u_cor (
            .i_clk (i_clk),
            .i_en  (en[S_COR0+i]),
            .i_x   (x_ch[i]),
            .i_y   (y_ch[i]),
            .i_z   (z_ch[i]),
            .o_x   (x_ch[i+1]),
            .o_y   (y_ch[i+1]),
            .o_z   (z_ch[i+1])
        );
    end

    // multiply
    prtp_pkg::t_item    mi;
    logic signed [31:0] cs_c;
    logic signed [31:0] cs_s;
    logic signed [32:0] d0;
    logic signed [32:0] d1;
    logic signed [32:0] a0, a1, a2, a3;
    logic signed [31:0] b0, b1, b2, b3;
    logic signed [31:0] fov_s;
    logic signed [64:0] r_m0, r_m1, r_m2, r_m3;

    always_comb begin
        mi    = r_item[S_MUL-1];
        cs_c  = mi.neg ? -x_ch[TRIG_STAGES] : x_ch[TRIG_STAGES];
        cs_s  = mi.neg ? -y_ch[TRIG_STAGES] : y_ch[TRIG_STAGES];
        fov_s = $signed({1'b0, r_fov});
        case (mi.axis)
            prtp_pkg::AX_X: begin
                d0 = 33'(mi.pz) - 33'(mi.pivz);
                d1 = 33'(mi.py) - 33'(mi.pivy);
            end
            prtp_pkg::AX_Y: begin
                d0 = 33'(mi.px) - 33'(mi.pivx);
                d1 = 33'(mi.pz) - 33'(mi.pivz);
            end
            default: begin
                d0 = 33'(mi.px) - 33'(mi.pivx);
                d1 = 33'(mi.py) - 33'(mi.pivy);
            end
        endcase
        if (mi.func == prtp_pkg::FN_PROJECT) begin
            a0 = 33'(mi.px); b0 = fov_s;
            a1 = 33'(mi.py); b1 = r_vx;
            a2 = 33'(mi.pz); b2 = fov_s;
            a3 = 33'(mi.py); b3 = r_vy;
        end else begin
            a0 = d0; b0 = cs_c;
            a1 = d1; b1 = cs_s;
            a2 = d0; b2 = cs_s;
            a3 = d1; b3 = cs_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_MUL]) begin
            r_m0 <= a0 * b0;
            r_m1 <= a1 * b1;
            r_m2 <= a2 * b2;
            r_m3 <= a3 * b3;
        end
    end

    // sums
    prtp_pkg::t_item    si;
    logic signed [65:0] r_s0;
    logic signed [65:0] r_s1;
    logic signed [32:0] r_den;

    assign si = r_item[S_SUM-1];

    always_ff @(posedge i_clk) begin
        if (en[S_SUM]) begin
            r_s0  <= (si.func == prtp_pkg::FN_PROJECT) ? 66'(r_m0) + 66'(r_m1)
                                                       : 66'(r_m0) - 66'(r_m1);
            r_s1  <= 66'(r_m2) + 66'(r_m3);
            r_den <= $signed({2'b00, r_fov}) + 33'(si.py);
        end
    end

    // round, pivot, translate, divider setup
    prtp_pkg::t_item    pi;
    prtp_pkg::t_res     n_res;
    logic signed [65:0] rs0, rs1;
    logic signed [38:0] w0, w1;
    logic signed [31:0] q0, q1;
    logic signed [31:0] tr;
    logic               den_neg;
    logic [32:0]        dabs;
    logic [65:0]        magx, magz, lim;
    logic [63:0]        n_remx, n_remz;

    always_comb begin
        pi  = r_item[S_POST-1];
        rs0 = r_s0 + (66'sd1 <<< (prtp_pkg::CS_FRAC - 1));
        rs1 = r_s1 + (66'sd1 <<< (prtp_pkg::CS_FRAC - 1));
        tr  = sat39(39'(pi.amount) + 39'(pi.px));
        case (pi.axis)
            prtp_pkg::AX_X: begin
                w0 = 39'($signed(rs0[65:prtp_pkg::CS_FRAC])) + 39'(pi.pivz);
                w1 = 39'($signed(rs1[65:prtp_pkg::CS_FRAC])) + 39'(pi.pivy);
                tr = sat39(39'(pi.amount) + 39'(pi.px));
            end
            prtp_pkg::AX_Y: begin
                w0 = 39'($signed(rs0[65:prtp_pkg::CS_FRAC])) + 39'(pi.pivx);
                w1 = 39'($signed(rs1[65:prtp_pkg::CS_FRAC])) + 39'(pi.pivz);
                tr = sat39(39'(pi.amount) + 39'(pi.py));
            end
            default: begin
                w0 = 39'($signed(rs0[65:prtp_pkg::CS_FRAC])) + 39'(pi.pivx);
                w1 = 39'($signed(rs1[65:prtp_pkg::CS_FRAC])) + 39'(pi.pivy);
                tr = sat39(39'(pi.amount) + 39'(pi.pz));
            end
        endcase
        q0 = sat39(w0);
        q1 = sat39(w1);

        n_res.ox = pi.px;
        n_res.oy = pi.py;
        n_res.oz = pi.pz;
        if (pi.func == prtp_pkg::FN_ROTATE) begin
            case (pi.axis)
                prtp_pkg::AX_X: begin
                    n_res.oz = q0;
                    n_res.oy = q1;
                end
                prtp_pkg::AX_Y: begin
                    n_res.ox = q0;
                    n_res.oz = q1;
                end
                prtp_pkg::AX_Z: begin
                    n_res.ox = q0;
                    n_res.oy = q1;
                end
                default: ;
            endcase
        end else if (pi.func == prtp_pkg::FN_TRANSLATE) begin
            case (pi.axis)
                prtp_pkg::AX_X: n_res.ox = tr;
                prtp_pkg::AX_Y: n_res.oy = tr;
                prtp_pkg::AX_Z: n_res.oz = tr;
                default: ;
            endcase
        end

        den_neg = r_den[32];
        dabs    = den_neg ? 33'(-r_den) : 33'(r_den);
        magx    = r_s0[65] ? 66'(-r_s0) : 66'(r_s0);
        magz    = r_s1[65] ? 66'(-r_s1) : 66'(r_s1);
        lim     = 66'(dabs) << QB;

        n_res.proj = (pi.func == prtp_pkg::FN_PROJECT);
        n_res.dz   = (r_den == '0);
        if (n_res.dz) begin
            n_res.negx = r_s0[65];
            n_res.negz = r_s1[65];
            n_res.ovfx = (r_s0 != '0);
            n_res.ovfz = (r_s1 != '0);
        end else begin
            n_res.negx = r_s0[65] ^ den_neg;
            n_res.negz = r_s1[65] ^ den_neg;
            n_res.ovfx = (magx >= lim);
            n_res.ovfz = (magz >= lim);
        end
        n_remx = magx[63:0];
        n_remz = magz[63:0];
    end

    prtp_pkg::t_res r_res [QB+1];
    logic [63:0]    r_remx, r_remz;
    logic [32:0]    r_dabs;

    always_ff @(posedge i_clk) begin
        if (en[S_POST]) begin
            r_res[0] <= n_res;
            r_remx   <= n_remx;
            r_remz   <= n_remz;
            r_dabs   <= dabs;
        end
    end

    // divider chains
    logic [63:0]   remx_ch [QB+1];
    logic [63:0]   remz_ch [QB+1];
    logic [32:0]   denx_ch [QB+1];
    logic [32:0]   denz_ch [QB+1];
    logic [QB-1:0] qx_ch   [QB+1];
    logic [QB-1:0] qz_ch   [QB+1];

    assign remx_ch[0] = r_remx;
    assign remz_ch[0] = r_remz;
    assign denx_ch[0] = r_dabs;
    assign denz_ch[0] = r_dabs;
    assign qx_ch[0]   = '0;
    assign qz_ch[0]   = '0;

    for (genvar j = 0; j < QB; j++) begin : g_div
        prtp_div_cell #(
            .K (QB - 1 - j)
        ) u_divx (
            .i_clk (i_clk),
            .i_en  (en[S_POST+1+j]),
            .i_rem (remx_ch[j]),
            .i_den (denx_ch[j]),
            .i_q   (qx_ch[j]),
            .o_rem (remx_ch[j+1]),
            .o_den (denx_ch[j+1]),
            .o_q   (qx_ch[j+1])
        );
        prtp_div_cell #(
            .K (QB - 1 - j)
        ) u_divz (
            .i_clk (i_clk),
            .i_en  (en[S_POST+1+j]),
            .i_rem (remz_ch[j]),
            .i_den (denz_ch[j]),
            .i_q   (qz_ch[j]),
            .o_rem (remz_ch[j+1]),
            .o_den (denz_ch[j+1]),
            .o_q   (qz_ch[j+1])
        );
        always_ff @(posedge i_clk) begin
            if (en[S_POST+1+j]) begin
                r_res[j+1] <= r_res[j];
            end
        end
    end

    // final select
    prtp_pkg::t_res     fr;
    logic signed [31:0] n_scr_x, n_scr_y;
    logic signed [31:0] r_out_x, r_out_y, r_out_z, r_scr_x, r_scr_y;
    logic               r_err;

    always_comb begin
        fr = r_res[QB];
        if (!fr.proj) begin
            n_scr_x = '0;
        end else if (fr.ovfx) begin
            n_scr_x = fr.negx ? prtp_pkg::INT_MIN : prtp_pkg::INT_MAX;
        end else if (fr.dz) begin
            n_scr_x = '0;
        end else begin
            n_scr_x = fr.negx ? -$signed(32'(qx_ch[QB])) : $signed(32'(qx_ch[QB]));
        end
        if (!fr.proj) begin
            n_scr_y = '0;
        end else if (fr.ovfz) begin
            n_scr_y = fr.negz ? prtp_pkg::INT_MIN : prtp_pkg::INT_MAX;
        end else if (fr.dz) begin
            n_scr_y = '0;
        end else begin
            n_scr_y = fr.negz ? -$signed(32'(qz_ch[QB])) : $signed(32'(qz_ch[QB]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_FIN]) begin
            r_out_x <= fr.ox;
            r_out_y <= fr.oy;
            r_out_z <= fr.oz;
            r_scr_x <= n_scr_x;
            r_scr_y <= n_scr_y;
            r_err   <= fr.proj & fr.dz;
        end
    end

    assign o_out_x        = r_out_x;
    assign o_out_y        = r_out_y;
    assign o_out_z        = r_out_z;
    assign o_screen_x     = r_scr_x;
    assign o_screen_y     = r_scr_y;
    assign o_divide_error = r_err;

    `PRTP_ASSERT_IMP(a_stall_needs_item, o_stall, r_vld[0], "input stalled while first stage empty")
    `PRTP_ASSERT_NXT(a_accept_lands, i_valid && !o_stall, r_vld[0], "accepted item lost at entry")
    `PRTP_ASSERT_IMP(a_err_saturates, o_valid && o_divide_error, (o_screen_x == prtp_pkg::INT_MAX) || (o_screen_x == prtp_pkg::INT_MIN) || (o_screen_x == 32'sd0), "divide error without saturated screen x")

endmodule

[tb/sv/point_rotate_translate_project_test.sv]
// Self-checking testbench for point_rotate_translate_project: rotate, translate and
// project items are checked against directed results or an in-bench point transform model.
// Depends on prtp_pkg and the point_rotate_translate_project RTL.
`timescale 1ns / 1ps
module point_rotate_translate_project_test;
    import prtp_pkg::*;

    localparam int FRAC = 16;
    localparam int TRIG = 16;
    localparam int DRAIN_CYCLES = 120;
    localparam int LONG_HOLD = 400;
    localparam int ITEMS_PER_PHASE = 325;

    localparam logic [1:0] FN_UNDEF = 2'd3;
    localparam logic [1:0] AX_UNDEF = 2'd3;

    typedef struct packed {
        logic [1:0]         fn;
        logic [1:0]         ax;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] amt;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] qz;
    } point_cmd_t;

    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic               err;
    } point_res_t;

    typedef struct packed {
        point_cmd_t cmd;
        logic       known;
        point_res_t res;
    } directed_row_t;

    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam logic signed [31:0] FOV0 = 32'sd16777216;
    localparam point_res_t NO_RES = '0;

    localparam int N_ROWS = 22;
    localparam directed_row_t DIRECTED [N_ROWS] = '{
        '{'{FN_TRANSLATE, AX_X, INT_MAX, 0, 0, ONE, 0, 0, 0}, 1'b1,
          '{INT_MAX, 0, 0, 0, 0, 1'b0}},
        '{'{FN_TRANSLATE, AX_Y, 0, INT_MIN, 0, INT_MIN, 0, 0, 0}, 1'b1,
          '{0, INT_MIN, 0, 0, 0, 1'b0}},
        '{'{FN_TRANSLATE, AX_Z, 0, 0, 5 * ONE, -2 * ONE, 0, 0, 0}, 1'b1,
          '{0, 0, 3 * ONE, 0, 0, 1'b0}},
        '{'{FN_TRANSLATE, AX_UNDEF, ONE, 2 * ONE, 3 * ONE, INT_MAX, 0, 0, 0}, 1'b1,
          '{ONE, 2 * ONE, 3 * ONE, 0, 0, 1'b0}},
        '{'{FN_ROTATE, AX_UNDEF, INT_MIN, INT_MAX, -1, 90 * ONE, 5, 6, 7}, 1'b1,
          '{INT_MIN, INT_MAX, -1, 0, 0, 1'b0}},
        '{'{FN_UNDEF, AX_X, -ONE, INT_MAX, INT_MIN, INT_MAX, -1, -1, -1}, 1'b1,
          '{-ONE, INT_MAX, INT_MIN, 0, 0, 1'b0}},
        '{'{FN_PROJECT, AX_X, ONE, -FOV0, 2 * ONE, 0, 0, 0, 0}, 1'b1,
          '{ONE, -FOV0, 2 * ONE, INT_MAX, INT_MAX, 1'b1}},
        '{'{FN_PROJECT, AX_Z, -ONE, -FOV0, 0, 0, 0, 0, 0}, 1'b1,
          '{-ONE, -FOV0, 0, INT_MIN, 0, 1'b1}},
        '{'{FN_PROJECT, AX_Y, 7 * ONE, 0, -3 * ONE, 0, 0, 0, 0}, 1'b1,
          '{7 * ONE, 0, -3 * ONE, 7 * ONE, -3 * ONE, 1'b0}},
        '{'{FN_ROTATE, AX_X, 0, ONE, 10 * ONE, 90 * ONE, 0, 0, 0}, 1'b0, NO_RES},
        '{'{FN_ROTATE, AX_Y, 3 * ONE, 0, 0, -90 * ONE, ONE, 0, ONE}, 1'b0, NO_RES},
        '{'{FN_ROTATE, AX_Z, 3 * ONE, 4 * ONE, 0, 180 * ONE, 0, 0, 0}, 1'b0, NO_RES},
        '{'{FN_ROTATE, AX_Z, ONE, 0, 0, 360 * ONE, 0, 0, 0}, 1'b0, NO_RES},
        '{'{FN_ROTATE, AX_X, INT_MAX, INT_MAX, INT_MAX, 45 * ONE, INT_MIN, INT_MIN, INT_MIN},
          1'b0, NO_RES},
        '{'{FN_ROTATE, AX_Y, INT_MIN, INT_MIN, INT_MIN, 135 * ONE, INT_MAX, INT_MAX, INT_MAX},
          1'b0, NO_RES},
        '{'{FN_ROTATE, AX_Z, INT_MAX, INT_MIN, 0, INT_MAX, 0, 0, 0}, 1'b0, NO_RES},
        '{'{FN_ROTATE, AX_X, 0, INT_MAX, INT_MIN, INT_MIN, 0, 0, 0}, 1'b0, NO_RES},
        '{'{FN_ROTATE, AX_Z, 2 * ONE, 0, 0, -181 * ONE, 0, 0, 0}, 1'b0, NO_RES},
        '{'{FN_ROTATE, AX_Y, 2 * ONE, 0, 5 * ONE, 91 * ONE, 0, 0, 0}, 1'b0, NO_RES},
        '{'{FN_PROJECT, AX_X, INT_MAX, INT_MAX, INT_MIN, 0, 0, 0, 0}, 1'b0, NO_RES},
        '{'{FN_PROJECT, AX_Y, INT_MIN, INT_MIN, INT_MAX, -1, 0, 0, 0}, 1'b0, NO_RES},
        '{'{FN_PROJECT, AX_Z, 3 * ONE, -FOV0 + 1, -5 * ONE, 0, 0, 0, 0}, 1'b0, NO_RES}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_func;
    logic [1:0]         i_axis_sel;
    logic signed [31:0] i_point_x;
    logic signed [31:0] i_point_y;
    logic signed [31:0] i_point_z;
    logic signed [31:0] i_amount;
    logic signed [31:0] i_pivot_x;
    logic signed [31:0] i_pivot_y;
    logic signed [31:0] i_pivot_z;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic signed [31:0] o_out_z;
    logic signed [31:0] o_screen_x;
    logic signed [31:0] o_screen_y;
    logic               o_divide_error;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    point_rotate_translate_project uut (.*);

    logic [30:0]        fov_reg;
    logic signed [31:0] vx_reg;
    logic signed [31:0] vy_reg;

    point_res_t pending_points[$];
    int  mismatches;
    int  results_seen;
    int  items_sent;
    int  div_zero_seen;
    bit  hold_long;
    bit  failed;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("point_rotate_translate_project test failed");
        $finish;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void cordic_deg(input longint amt, output longint c, output longint s);
        longint full, half, quarter, a, x, y, z, xs, ys;
        bit flip;
        full = 360 * (64'sd1 <<< FRAC);
        half = 180 * (64'sd1 <<< FRAC);
        quarter = 90 * (64'sd1 <<< FRAC);
        flip = 1'b0;
        a = amt % full;
        if (a < 0) a += full;
        if (a > half) a -= full;
        if (a > quarter) begin
            a -= half;
            flip = 1'b1;
        end else if (a < -quarter) begin
            a += half;
            flip = 1'b1;
        end
        z = a * (64'sd1 <<< (24 - FRAC));
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < TRIG && i < ATAN_COUNT; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys;
                y += xs;
                z -= longint'(ATAN_DEG[i]);
            end else begin
                x += ys;
                y -= xs;
                z += longint'(ATAN_DEG[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic void turn_pair(inout longint p0, inout longint p1,
                                      input longint a0, input longint a1,
                                      input longint c, input longint s);
        longint d0, d1, n0, n1, rnd;
        rnd = 64'sd1 <<< (CS_FRAC - 1);
        d0 = p0 - a0;
        d1 = p1 - a1;
        n0 = (d0 * c - d1 * s + rnd) >>> CS_FRAC;
        n1 = (d0 * s + d1 * c + rnd) >>> CS_FRAC;
        p0 = clamp32(n0 + a0);
        p1 = clamp32(n1 + a1);
    endfunction

    function automatic longint perspective(longint c, longint y, longint v, longint fov,
                                           inout logic err);
        longint num, den;
        num = c * fov + y * v;
        den = fov + y;
        if (den == 0) begin
            err = 1'b1;
            if (num > 0) return 64'sd2147483647;
            if (num < 0) return -64'sd2147483648;
            return 0;
        end
        return clamp32(num / den);
    endfunction

    function automatic point_res_t transform_point(point_cmd_t cmd);
        longint p[3];
        longint c, s, sx, sy;
        logic err;
        point_res_t r;
        p[0] = cmd.px;
        p[1] = cmd.py;
        p[2] = cmd.pz;
        sx = 0;
        sy = 0;
        err = 1'b0;
        if (cmd.fn == FN_ROTATE && cmd.ax != AX_UNDEF) begin
            cordic_deg(longint'(cmd.amt), c, s);
            case (cmd.ax)
                AX_X: turn_pair(p[2], p[1], cmd.qz, cmd.qy, c, s);
                AX_Y: turn_pair(p[0], p[2], cmd.qx, cmd.qz, c, s);
                default: turn_pair(p[0], p[1], cmd.qx, cmd.qy, c, s);
            endcase
        end else if (cmd.fn == FN_TRANSLATE && cmd.ax != AX_UNDEF) begin
            p[cmd.ax] = clamp32(p[cmd.ax] + longint'(cmd.amt));
        end else if (cmd.fn == FN_PROJECT) begin
            sx = perspective(p[0], p[1], vx_reg, longint'({1'b0, fov_reg}), err);
            sy = perspective(p[2], p[1], vy_reg, longint'({1'b0, fov_reg}), err);
        end
        r.ox = p[0][31:0];
        r.oy = p[1][31:0];
        r.oz = p[2][31:0];
        r.sx = sx[31:0];
        r.sy = sy[31:0];
        r.err = err;
        return r;
    endfunction

    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return INT_MAX;
            1: return INT_MIN;
            2: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
            3, 4: return $signed($urandom_range(0, 200)) * ONE - 100 * ONE;
            default: return $urandom;
        endcase
    endfunction

    function automatic point_cmd_t random_cmd();
        point_cmd_t cmd;
        int pick;
        pick = $urandom_range(0, 99);
        cmd.fn = (pick < 40) ? FN_ROTATE : (pick < 65) ? FN_TRANSLATE :
                 (pick < 95) ? FN_PROJECT : FN_UNDEF;
        cmd.ax = ($urandom_range(0, 19) == 0) ? AX_UNDEF : 2'($urandom_range(0, 2));
        cmd.px = pick_coord();
        cmd.py = pick_coord();
        cmd.pz = pick_coord();
        cmd.qx = pick_coord();
        cmd.qy = pick_coord();
        cmd.qz = pick_coord();
        case ($urandom_range(0, 3))
            0: cmd.amt = $signed($urandom_range(0, 720)) * ONE - 360 * ONE;
            1: cmd.amt = $signed($urandom_range(0, 2)) * 90 * ONE - 90 * ONE;
            default: cmd.amt = pick_coord();
        endcase
        if (cmd.fn == FN_PROJECT && $urandom_range(0, 3) == 0)
            cmd.py = -$signed({1'b0, fov_reg}) + $signed($urandom_range(0, 2)) - 1;
        return cmd;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_FOV: fov_reg = data[30:0];
            CFG_VX:  vx_reg = data;
            default: vy_reg = data;
        endcase
    endtask

    task automatic send_point(point_cmd_t cmd, bit quiet, bit known, point_res_t res);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= cmd.fn;
        i_axis_sel <= cmd.ax;
        i_point_x <= cmd.px;
        i_point_y <= cmd.py;
        i_point_z <= cmd.pz;
        i_amount <= cmd.amt;
        i_pivot_x <= cmd.qx;
        i_pivot_y <= cmd.qy;
        i_pivot_z <= cmd.qz;
        do @(posedge i_clk); while (o_stall);
        pending_points.push_back(known ? res : transform_point(cmd));
        items_sent++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        wait (pending_points.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int w, n;
        bit quiet;
        point_res_t want, got;
        n = 0;
        forever begin
            quiet = ((n / 60) % 4) == 3;
            if (hold_long) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_long = 1'b0;
            end else begin
                w = quiet ? 0 : $urandom_range(0, 8);
                if (w > 0) begin
                    i_stall <= 1'b1;
                    repeat (w) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && i_rst_n));
            got = '{o_out_x, o_out_y, o_out_z, o_screen_x, o_screen_y, o_divide_error};
            results_seen++;
            n++;
            if (got.err) div_zero_seen++;
            if (pending_points.size() == 0) begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending_points.pop_front();
                if (got !== want) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    initial begin
        logic [31:0] fov_set [6];
        logic [31:0] vx_set [6];
        logic [31:0] vy_set [6];
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        div_zero_seen = 0;
        hold_long = 1'b0;
        failed = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b1;
        i_func = '0;
        i_axis_sel = '0;
        i_point_x = '0;
        i_point_y = '0;
        i_point_z = '0;
        i_amount = '0;
        i_pivot_x = '0;
        i_pivot_y = '0;
        i_pivot_z = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_FOV;
        i_cfg_data = '0;
        fov_reg = FOV_RESET;
        vx_reg = 0;
        vy_reg = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++)
            send_point(DIRECTED[r].cmd, r % 3 == 0, DIRECTED[r].known, DIRECTED[r].res);
        settle();

        fov_set = '{32'h7fff_ffff, 32'd1, 32'h0001_0000, $urandom, 32'h0100_0000, $urandom};
        vx_set = '{INT_MAX, INT_MIN, 32'd0, $urandom, 32'h0040_0000, $urandom};
        vy_set = '{INT_MIN, INT_MAX, 32'hffff_0000, $urandom, 32'd0, $urandom};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_FOV, fov_set[ph]);
            write_reg(CFG_VX, vx_set[ph]);
            write_reg(CFG_VY, vy_set[ph]);
            if (ph == 1) hold_long = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_point(random_cmd(), ((k / 40) % 3) == 2, 1'b0, NO_RES);
            settle();
        end

        $display("sent %0d items over 7 register settings, checked %0d results",
                 items_sent, results_seen);
        $display("%0d projections hit a zero divisor, %0d mismatches", div_zero_seen, mismatches);
        if (!failed && pending_points.size() == 0)
            $display("point_rotate_translate_project test passed");
        else
            $display("point_rotate_translate_project test failed");
        $finish;
    end
endmodule
